/* hw/rtl/teq_pkg.sv */
// Shared types and constants for the timer expiry queue.
// No dependencies; used by the interface, controller, datapath and top files.
package teq_pkg;

  localparam int unsigned DEPTH    = 16;
  localparam int unsigned ID_COUNT = 256;

  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned MARK_W = $clog2(ID_COUNT);

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned ID_W   = 8;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned PER_W  = 32;
  localparam int unsigned KIND_W = 2;

  // input operation codes
  localparam logic [FUNC_W-1:0] FUNC_ADD     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CANCEL  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd2;

  // result kind codes
  localparam logic [KIND_W-1:0] KIND_ADD_ACK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CANCEL_ACK = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIRED      = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DONE       = 2'd3;

  // controller states, one-hot
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_POP   = 5'b00100,
    S_REARM = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic do_add;
    logic do_cancel;
    logic do_pop;
    logic do_rearm;
    logic emit_done;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              head_due;
    logic              rearm_left;
    logic              out_free;
  } sts_t;

endpackage

/* hw/rtl/teq_if.sv */
// Handshake channel interfaces for the timer expiry queue.
// Depends on teq_pkg for field widths.
interface teq_in_if;
  logic                           valid;
  logic                           ready;
  logic [teq_pkg::FUNC_W-1:0]     func;
  logic [teq_pkg::ID_W-1:0]       timer_id;
  logic [teq_pkg::TIME_W-1:0]     expiry_time;
  logic [teq_pkg::PER_W-1:0]      period;
  logic [teq_pkg::TIME_W-1:0]     now_time;

  modport source (output valid, func, timer_id, expiry_time, period, now_time, input ready);
  modport sink (input valid, func, timer_id, expiry_time, period, now_time, output ready);
endinterface

interface teq_out_if;
  logic                       valid;
  logic                       ready;
  logic [teq_pkg::KIND_W-1:0] kind;
  logic [teq_pkg::ID_W-1:0]   fired_id;
  logic                       earliest_changed;
  logic                       queue_full;
  logic                       has_pending;
  logic [teq_pkg::TIME_W-1:0] next_deadline;
  logic                       last;

  modport source (output valid, kind, fired_id, earliest_changed, queue_full, has_pending,
                  next_deadline, last, input ready);
  modport sink (input valid, kind, fired_id, earliest_changed, queue_full, has_pending,
                next_deadline, last, output ready);
endinterface

/* hw/rtl/timer_expiry_queue.sv */
// Timer expiry queue: add, cancel and advance over a sorted queue of timers.
// Add and cancel: the input item is captured, then the execute state writes the result register.
// Advance with n due entries: n head pops at one per cycle while the output register is free,
// then n re-arm steps, then the final done result is registered.
// Output stalls add cycles. One item is in work at a time; reset clears the count and id marks.
module timer_expiry_queue (
  input logic       clk_i,
  input logic       rst_ni,
  teq_in_if.sink    in_if,
  teq_out_if.source out_if
);

  teq_pkg::cmd_t cmd;
  teq_pkg::sts_t sts;
  logic          in_ready;

  assign in_if.ready = in_ready;

  // sequencer
  teq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // queue storage and result path
  teq_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .func_i             (in_if.func),
    .timer_id_i         (in_if.timer_id),
    .expiry_time_i      (in_if.expiry_time),
    .period_i           (in_if.period),
    .now_time_i         (in_if.now_time),
    .out_valid_o        (out_if.valid),
    .out_ready_i        (out_if.ready),
    .kind_o             (out_if.kind),
    .fired_id_o         (out_if.fired_id),
    .earliest_changed_o (out_if.earliest_changed),
    .queue_full_o       (out_if.queue_full),
    .has_pending_o      (out_if.has_pending),
    .next_deadline_o    (out_if.next_deadline),
    .last_o             (out_if.last)
  );

  // checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in work");

  a_pop_only_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.do_pop |-> sts.head_due)
    else $error("pop of an entry that is not due");

  a_rearm_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.do_rearm |-> sts.rearm_left)
    else $error("re-arm walk past removed entries");

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.do_add || cmd.do_cancel || cmd.emit_done || cmd.do_pop) |-> sts.out_free)
    else $error("result written into a busy output register");

endmodule

/* hw/rtl/teq_ctrl.sv */
// Sequencing state machine of the timer expiry queue.
// Depends on teq_pkg; drives commands into teq_dp.
module teq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  teq_pkg::sts_t sts_i,
  output teq_pkg::cmd_t cmd_o
);

  teq_pkg::state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      teq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = teq_pkg::S_EXEC;
        end
      end
      teq_pkg::S_EXEC: begin
        case (sts_i.func)
          teq_pkg::FUNC_ADD: begin
            if (sts_i.out_free) begin
              cmd_o.do_add = 1'b1;
              state_d      = teq_pkg::S_IDLE;
            end
          end
          teq_pkg::FUNC_CANCEL: begin
            if (sts_i.out_free) begin
              cmd_o.do_cancel = 1'b1;
              state_d         = teq_pkg::S_IDLE;
            end
          end
          teq_pkg::FUNC_ADVANCE: state_d = teq_pkg::S_POP;
          default: state_d = teq_pkg::S_IDLE;
        endcase
      end
      // remove due entries from the head one per cycle while the output register is free
      teq_pkg::S_POP: begin
        if (sts_i.head_due) begin
          if (sts_i.out_free) cmd_o.do_pop = 1'b1;
        end else begin
          state_d = teq_pkg::S_REARM;
        end
      end
      // walk the removed entries in expiry order
      teq_pkg::S_REARM: begin
        if (sts_i.rearm_left) cmd_o.do_rearm = 1'b1;
        else state_d = teq_pkg::S_DONE;
      end
      teq_pkg::S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit_done = 1'b1;
          state_d         = teq_pkg::S_IDLE;
        end
      end
      default: state_d = teq_pkg::S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= teq_pkg::S_IDLE;
    else state_q <= state_d;
  end

endmodule

/* hw/rtl/teq_dp.sv */
// Datapath of the timer expiry queue: sorted entry store, id marks,
// removed-entry buffer and output register. Depends on teq_pkg.
module teq_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  teq_pkg::cmd_t                  cmd_i,
  output teq_pkg::sts_t                  sts_o,
  input  logic [teq_pkg::FUNC_W-1:0]     func_i,
  input  logic [teq_pkg::ID_W-1:0]       timer_id_i,
  input  logic [teq_pkg::TIME_W-1:0]     expiry_time_i,
  input  logic [teq_pkg::PER_W-1:0]      period_i,
  input  logic [teq_pkg::TIME_W-1:0]     now_time_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [teq_pkg::KIND_W-1:0]     kind_o,
  output logic [teq_pkg::ID_W-1:0]       fired_id_o,
  output logic                           earliest_changed_o,
  output logic                           queue_full_o,
  output logic                           has_pending_o,
  output logic [teq_pkg::TIME_W-1:0]     next_deadline_o,
  output logic                           last_o
);

  // sorted entries, index 0 is earliest
  logic [teq_pkg::TIME_W-1:0] ent_exp_q [teq_pkg::DEPTH];
  logic [teq_pkg::TIME_W-1:0] ent_exp_d [teq_pkg::DEPTH];
  logic [teq_pkg::PER_W-1:0]  ent_per_q [teq_pkg::DEPTH];
  logic [teq_pkg::PER_W-1:0]  ent_per_d [teq_pkg::DEPTH];
  logic [teq_pkg::ID_W-1:0]   ent_id_q  [teq_pkg::DEPTH];
  logic [teq_pkg::ID_W-1:0]   ent_id_d  [teq_pkg::DEPTH];
  logic [teq_pkg::CNT_W-1:0]  cnt_q, cnt_d;

  logic [teq_pkg::ID_COUNT-1:0] mark_q, mark_d;

  // removed entries, holding their re-arm time
  logic [teq_pkg::TIME_W-1:0] gone_t_q  [teq_pkg::DEPTH];
  logic [teq_pkg::PER_W-1:0]  gone_per_q [teq_pkg::DEPTH];
  logic [teq_pkg::ID_W-1:0]   gone_id_q [teq_pkg::DEPTH];
  logic [teq_pkg::CNT_W-1:0]  gcnt_q, ridx_q;

  // captured input item
  logic [teq_pkg::FUNC_W-1:0] func_q;
  logic [teq_pkg::ID_W-1:0]   id_q;
  logic [teq_pkg::TIME_W-1:0] exp_q;
  logic [teq_pkg::PER_W-1:0]  per_q;
  logic [teq_pkg::TIME_W-1:0] now_q;

  // output register
  logic                       ovalid_q;
  logic [teq_pkg::KIND_W-1:0] okind_q;
  logic [teq_pkg::ID_W-1:0]   oid_q;
  logic                       oec_q, oqf_q, ohp_q, olast_q;
  logic [teq_pkg::TIME_W-1:0] ond_q;

  logic [teq_pkg::PTR_W-1:0]  gptr, rptr;
  logic [teq_pkg::MARK_W-1:0] head_mark, r_mark, in_mark;
  logic                       head_valid, r_valid, full, empty, ec;
  logic [teq_pkg::TIME_W:0]   rearm_sum;
  logic [teq_pkg::TIME_W-1:0] rearm_t;
  logic                       ins_en;
  logic [teq_pkg::TIME_W-1:0] ins_exp;
  logic [teq_pkg::PER_W-1:0]  ins_per;
  logic [teq_pkg::ID_W-1:0]   ins_id;
  logic [teq_pkg::DEPTH-1:0]  gt;
  logic                       emit;

  assign gptr      = gcnt_q[teq_pkg::PTR_W-1:0];
  assign rptr      = ridx_q[teq_pkg::PTR_W-1:0];
  assign head_mark = teq_pkg::MARK_W'(ent_id_q[0] % teq_pkg::ID_COUNT);
  assign r_mark    = teq_pkg::MARK_W'(gone_id_q[rptr] % teq_pkg::ID_COUNT);
  assign in_mark   = teq_pkg::MARK_W'(id_q % teq_pkg::ID_COUNT);
  assign head_valid = mark_q[head_mark];
  assign r_valid    = mark_q[r_mark];
  assign full      = (cnt_q == teq_pkg::CNT_W'(teq_pkg::DEPTH));
  assign empty     = (cnt_q == '0);
  assign ec        = empty || (exp_q < ent_exp_q[0]);

  // saturating re-arm time of the head entry
  assign rearm_sum = {1'b0, now_q} + (teq_pkg::TIME_W + 1)'(ent_per_q[0]);
  assign rearm_t   = rearm_sum[teq_pkg::TIME_W] ? '1 : rearm_sum[teq_pkg::TIME_W-1:0];

  // insert source: new timer or re-armed periodic timer
  assign ins_en  = (cmd_i.do_add && !full) ||
                   (cmd_i.do_rearm && r_valid && gone_per_q[rptr] != '0);
  assign ins_exp = cmd_i.do_rearm ? gone_t_q[rptr] : exp_q;
  assign ins_per = cmd_i.do_rearm ? gone_per_q[rptr] : per_q;
  assign ins_id  = cmd_i.do_rearm ? gone_id_q[rptr] : id_q;

  // entries that must move up past the inserted one
  always_comb begin
    for (int j = 0; j < teq_pkg::DEPTH; j++) begin
      gt[j] = (teq_pkg::CNT_W'(j) < cnt_q) && (ent_exp_q[j] > ins_exp);
    end
  end

  // entry store next values
  always_comb begin
    cnt_d = cnt_q;
    for (int j = 0; j < teq_pkg::DEPTH; j++) begin
      ent_exp_d[j] = ent_exp_q[j];
      ent_per_d[j] = ent_per_q[j];
      ent_id_d[j]  = ent_id_q[j];
    end
    if (cmd_i.do_pop) begin
      for (int j = 0; j < teq_pkg::DEPTH - 1; j++) begin
        ent_exp_d[j] = ent_exp_q[j+1];
        ent_per_d[j] = ent_per_q[j+1];
        ent_id_d[j]  = ent_id_q[j+1];
      end
      cnt_d = cnt_q - 1'b1;
    end else if (ins_en) begin
      for (int j = 0; j < teq_pkg::DEPTH; j++) begin
        if (j > 0 && gt[(j > 0) ? j - 1 : 0]) begin
          ent_exp_d[j] = ent_exp_q[(j > 0) ? j - 1 : 0];
          ent_per_d[j] = ent_per_q[(j > 0) ? j - 1 : 0];
          ent_id_d[j]  = ent_id_q[(j > 0) ? j - 1 : 0];
        end else if (gt[j] || teq_pkg::CNT_W'(j) == cnt_q) begin
          ent_exp_d[j] = ins_exp;
          ent_per_d[j] = ins_per;
          ent_id_d[j]  = ins_id;
        end
      end
      cnt_d = cnt_q + 1'b1;
    end
  end

  // id marks
  always_comb begin
    mark_d = mark_q;
    if (cmd_i.do_add && !full) mark_d[in_mark] = 1'b1;
    else if (cmd_i.do_cancel) mark_d[in_mark] = 1'b0;
    else if (cmd_i.do_rearm && r_valid && gone_per_q[rptr] == '0) mark_d[r_mark] = 1'b0;
  end

  // entry store and marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      mark_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      mark_q <= mark_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < teq_pkg::DEPTH; j++) begin
      ent_exp_q[j] <= ent_exp_d[j];
      ent_per_q[j] <= ent_per_d[j];
      ent_id_q[j]  <= ent_id_d[j];
    end
  end

  // removed-entry buffer and walk pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gcnt_q <= '0;
      ridx_q <= '0;
    end else if (cmd_i.load) begin
      gcnt_q <= '0;
      ridx_q <= '0;
    end else begin
      if (cmd_i.do_pop) gcnt_q <= gcnt_q + 1'b1;
      if (cmd_i.do_rearm) ridx_q <= ridx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_pop) begin
      gone_t_q[gptr]   <= rearm_t;
      gone_per_q[gptr] <= ent_per_q[0];
      gone_id_q[gptr]  <= ent_id_q[0];
    end
  end

  // input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      id_q   <= timer_id_i;
      exp_q  <= expiry_time_i;
      per_q  <= period_i;
      now_q  <= now_time_i;
    end
  end

  // output register
  assign emit = cmd_i.do_add || cmd_i.do_cancel || cmd_i.emit_done ||
                (cmd_i.do_pop && head_valid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (emit) ovalid_q <= 1'b1;
    else if (out_ready_i) ovalid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      oid_q   <= '0;
      oec_q   <= 1'b0;
      oqf_q   <= 1'b0;
      olast_q <= 1'b1;
      ohp_q   <= !empty;
      ond_q   <= empty ? '0 : ent_exp_q[0];
      if (cmd_i.do_add) begin
        okind_q <= teq_pkg::KIND_ADD_ACK;
        if (full) begin
          oqf_q <= 1'b1;
        end else begin
          oec_q <= ec;
          ohp_q <= 1'b1;
          ond_q <= ec ? exp_q : ent_exp_q[0];
        end
      end else if (cmd_i.do_cancel) begin
        okind_q <= teq_pkg::KIND_CANCEL_ACK;
      end else if (cmd_i.do_pop) begin
        okind_q <= teq_pkg::KIND_FIRED;
        oid_q   <= ent_id_q[0];
        ohp_q   <= 1'b0;
        ond_q   <= '0;
        olast_q <= 1'b0;
      end else begin
        okind_q <= teq_pkg::KIND_DONE;
      end
    end
  end

  assign out_valid_o        = ovalid_q;
  assign kind_o             = okind_q;
  assign fired_id_o         = oid_q;
  assign earliest_changed_o = oec_q;
  assign queue_full_o       = oqf_q;
  assign has_pending_o      = ohp_q;
  assign next_deadline_o    = ond_q;
  assign last_o             = olast_q;

  // status to the controller
  assign sts_o.func       = func_q;
  assign sts_o.head_due   = !empty && (ent_exp_q[0] <= now_q);
  assign sts_o.rearm_left = (ridx_q != gcnt_q);
  assign sts_o.out_free   = !ovalid_q || out_ready_i;

endmodule

/* sim/teq_scoreboard.sv */
// Scoreboard for the timer expiry queue: timer queue predictor and result check.
// Depends on teq_pkg for widths and operation and result codes.
package teq_sb_pkg;
  import teq_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   fired_id;
    logic              earliest_changed;
    logic              queue_full;
    logic              has_pending;
    logic [TIME_W-1:0] next_deadline;
    logic              last;
  } timer_result_t;

  class timer_scoreboard;
    logic [TIME_W-1:0] q_expiry[$];
    logic [PER_W-1:0]  q_period[$];
    logic [ID_W-1:0]   q_ident[$];
    bit                id_mark[ID_COUNT];
    timer_result_t     pending_results[$];
    int unsigned       mismatches;
    int unsigned       fired_seen;

    function new();
      mismatches = 0;
      fired_seen = 0;
      foreach (id_mark[i]) id_mark[i] = 0;
    endfunction

    function int unsigned depth_used();
      return q_expiry.size();
    endfunction

    // sorted insert, ties after equal expiries
    function void insert_timer(logic [TIME_W-1:0] exp_t, logic [PER_W-1:0] per,
                               logic [ID_W-1:0] ident);
      int pos;
      pos = q_expiry.size();
      while (pos > 0 && q_expiry[pos-1] > exp_t) pos--;
      q_expiry.insert(pos, exp_t);
      q_period.insert(pos, per);
      q_ident.insert(pos, ident);
    endfunction

    function void push_status(logic [KIND_W-1:0] kind, logic ec, logic qf);
      timer_result_t r;
      r = '0;
      r.kind = kind;
      r.earliest_changed = ec;
      r.queue_full = qf;
      r.has_pending = q_expiry.size() > 0;
      r.next_deadline = r.has_pending ? q_expiry[0] : '0;
      r.last = 1'b1;
      pending_results = {pending_results, r};
    endfunction

    // predict the results of one accepted input transfer
    function void note_input(logic [FUNC_W-1:0] func, logic [ID_W-1:0] ident,
                             logic [TIME_W-1:0] exp_t, logic [PER_W-1:0] per,
                             logic [TIME_W-1:0] now_t);
      logic [TIME_W-1:0] gone_exp[$];
      logic [PER_W-1:0]  gone_per[$];
      logic [ID_W-1:0]   gone_id[$];
      logic [TIME_W:0]   sum;
      timer_result_t     r;
      logic              ec;
      int unsigned       m;
      case (func)
        FUNC_ADD: begin
          if (q_expiry.size() >= DEPTH) begin
            push_status(KIND_ADD_ACK, 1'b0, 1'b1);
          end else begin
            ec = (q_expiry.size() == 0) || (exp_t < q_expiry[0]);
            id_mark[ident % ID_COUNT] = 1;
            insert_timer(exp_t, per, ident);
            push_status(KIND_ADD_ACK, ec, 1'b0);
          end
        end
        FUNC_CANCEL: begin
          id_mark[ident % ID_COUNT] = 0;
          push_status(KIND_CANCEL_ACK, 1'b0, 1'b0);
        end
        FUNC_ADVANCE: begin
          while (q_expiry.size() > 0 && q_expiry[0] <= now_t) begin
            gone_exp = {gone_exp, q_expiry.pop_front()};
            gone_per = {gone_per, q_period.pop_front()};
            gone_id  = {gone_id, q_ident.pop_front()};
          end
          // fired decisions use marks from before the re-arm pass
          foreach (gone_id[i]) begin
            if (id_mark[gone_id[i] % ID_COUNT]) begin
              r = '0;
              r.kind = KIND_FIRED;
              r.fired_id = gone_id[i];
              pending_results = {pending_results, r};
            end
          end
          foreach (gone_id[i]) begin
            m = gone_id[i] % ID_COUNT;
            if (!id_mark[m]) continue;
            if (gone_per[i] != 0) begin
              sum = {1'b0, now_t} + (TIME_W + 1)'(gone_per[i]);
              if (sum[TIME_W]) sum = {1'b0, {TIME_W{1'b1}}};
              insert_timer(sum[TIME_W-1:0], gone_per[i], gone_id[i]);
            end else begin
              id_mark[m] = 0;
            end
          end
          push_status(KIND_DONE, 1'b0, 1'b0);
        end
        default: ;
      endcase
    endfunction

    // compare one output transfer with the oldest prediction
    function void check_result(timer_result_t got);
      timer_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending_results.pop_front();
      if (got.kind == KIND_FIRED) fired_seen++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass
endpackage

/* sim/testbench.sv */
// Top-level testbench for timer_expiry_queue: directed and random add, cancel and
// advance traffic, checked by the scoreboard. Depends on teq_pkg, teq_if, teq_sb_pkg.
module testbench;
  import teq_pkg::*;
  import teq_sb_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned RANDOM_ITEMS   = 180;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  teq_in_if  in_if();
  teq_out_if out_if();

  timer_expiry_queue i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if)
  );

  timer_scoreboard timer_sb = new();
  int unsigned     idle_cycles;
  bit              calm_phase;
  logic [TIME_W-1:0] sim_now;

  always #5 clk_i = ~clk_i;

  // input channel driver: one transfer, random idle bursts before it
  task automatic send_op(logic [FUNC_W-1:0] func, logic [ID_W-1:0] ident,
                         logic [TIME_W-1:0] exp_t, logic [PER_W-1:0] per,
                         logic [TIME_W-1:0] now_t);
    int unsigned gap;
    if (!calm_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.func        <= func;
    in_if.timer_id    <= ident;
    in_if.expiry_time <= exp_t;
    in_if.period      <= per;
    in_if.now_time    <= now_t;
    do @(posedge clk_i); while (!in_if.ready);
    timer_sb.note_input(func, ident, exp_t, per, now_t);
    @(negedge clk_i);
  endtask

  // output ready with random stall bursts
  initial begin
    int unsigned n;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (n > 0) begin
        n--;
        out_if.ready <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 8) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // output monitor and watchdog
  always @(posedge clk_i) begin
    timer_result_t got;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got.kind = out_if.kind;
        got.fired_id = out_if.fired_id;
        got.earliest_changed = out_if.earliest_changed;
        got.queue_full = out_if.queue_full;
        got.has_pending = out_if.has_pending;
        got.next_deadline = out_if.next_deadline;
        got.last = out_if.last;
        timer_sb.check_result(got);
      end
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  function automatic logic [TIME_W-1:0] rand_time();
    return {16'($urandom_range(0, 65535)), $urandom()};
  endfunction

  // stimulus
  initial begin
    int unsigned kind_sel;
    logic [ID_W-1:0] ident;
    in_if.valid = 1'b0;
    in_if.func = FUNC_ADD;
    in_if.timer_id = '0;
    in_if.expiry_time = '0;
    in_if.period = '0;
    in_if.now_time = '0;
    idle_cycles = 0;
    calm_phase = 0;
    sim_now = 1000;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, shared ids, ties, full queue, overflow re-arm
    send_op(FUNC_ADVANCE, 8'd0, '0, '0, '0);
    send_op(FUNC_ADD, 8'hFF, {TIME_W{1'b1}}, 32'hFFFF_FFFF, '0);
    send_op(FUNC_ADD, 8'h00, 48'd0, 32'd0, '0);
    send_op(FUNC_ADD, 8'h5A, 48'd100, 32'd0, '0);
    send_op(FUNC_ADD, 8'hA5, 48'd100, 32'hFFFF_FFFF, '0);
    send_op(FUNC_ADD, 8'h5A, 48'd100, 32'd7, '0);
    send_op(FUNC_CANCEL, 8'h00, '0, '0, '0);
    send_op(FUNC_ADVANCE, '0, '0, '0, 48'd100);
    send_op(FUNC_ADVANCE, '0, '0, '0, {TIME_W{1'b1}});
    send_op(FUNC_CANCEL, 8'hFF, '0, '0, '0);
    send_op(FUNC_CANCEL, 8'hA5, '0, '0, '0);
    send_op(FUNC_CANCEL, 8'h5A, '0, '0, '0);
    send_op(FUNC_ADVANCE, '0, '0, '0, {TIME_W{1'b1}});
    for (int i = 0; i < DEPTH + 2; i++)
      send_op(FUNC_ADD, 8'(i), 48'd50 - 48'(i), 32'(i & 1), '0);
    send_op(FUNC_UNUSED, 8'hFF, {TIME_W{1'b1}}, '1, '1);
    send_op(FUNC_ADVANCE, '0, '0, '0, {TIME_W{1'b1}});
    send_op(FUNC_ADVANCE, '0, '0, '0, {TIME_W{1'b1}});
    for (int i = 0; i < 16; i++) send_op(FUNC_CANCEL, 8'(i), '0, '0, '0);
    send_op(FUNC_ADVANCE, '0, '0, '0, {TIME_W{1'b1}});

    // random: mostly near-future timers with a small id pool, some wide values
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i >= RANDOM_ITEMS - 40) calm_phase = 1;
      kind_sel = $urandom_range(0, 19);
      ident = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 11));
      if (kind_sel < 9) begin
        if ($urandom_range(0, 9) == 0)
          send_op(FUNC_ADD, ident, rand_time(), $urandom(), '0);
        else
          send_op(FUNC_ADD, ident, sim_now + TIME_W'($urandom_range(0, 300)),
                  ($urandom_range(0, 2) == 0) ? 32'd0 : 32'($urandom_range(1, 200)), '0);
      end else if (kind_sel < 12) begin
        send_op(FUNC_CANCEL, ident, rand_time(), $urandom(), rand_time());
      end else if (kind_sel < 19) begin
        sim_now = sim_now + TIME_W'($urandom_range(0, 150));
        send_op(FUNC_ADVANCE, ident, rand_time(), $urandom(), sim_now);
      end else if ($urandom_range(0, 3) == 0) begin
        send_op(FUNC_UNUSED, ident, rand_time(), $urandom(), rand_time());
      end else begin
        // flush timers: cancel ids 0 to 11 and advance to the latest time, keeps queue from staying full forever
        send_op(FUNC_ADVANCE, ident, '0, '0, rand_time());
        for (int j = 0; j < 12; j++) send_op(FUNC_CANCEL, 8'(j), '0, '0, '0);
        send_op(FUNC_ADVANCE, '0, '0, '0, {TIME_W{1'b1}});
        sim_now = 1000;
        send_op(FUNC_ADVANCE, '0, '0, '0, {TIME_W{1'b1}});
      end
    end
    in_if.valid <= 1'b0;

    // drain
    while (timer_sb.pending_results.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (timer_sb.mismatches == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end
endmodule
